FILE: rtl/qrs_pkg.sv
// Shared types and constants for the quadratic root solver.
// Holds the beat structs for both channels and the status codes.
package qrs_pkg;

  localparam int WordBits = 32;
  localparam int FracBits = 16;

  typedef enum logic [1:0] {
    StFormula  = 2'd0,
    StShortcut = 2'd1,
    StNoReal   = 2'd2,
    StAZero    = 2'd3
  } status_e;

  typedef struct packed {
    logic signed [WordBits-1:0] coef_a;
    logic signed [WordBits-1:0] coef_b;
    logic signed [WordBits-1:0] coef_c;
  } coef_t;

  typedef struct packed {
    logic signed [WordBits-1:0] root_first;
    logic signed [WordBits-1:0] root_second;
    logic [1:0]                 status;
    logic                       saturated;
  } root_t;

endpackage

FILE: rtl/quadratic_root_solver_core.sv
// Quadratic root solver: takes a, b, c and gives two real roots, or a status code when it cannot.
// Depends on qrs_pkg for the beat structs and status codes.
//
// Usage:
//   Input beat (coef_i) carries a, b and c as signed fixed point values.
//   Output beat (root_o) carries both roots, a status code and a
//   saturation flag. Both channels use valid/stall; a beat moves on a
//   rising edge with valid high and stall low.
//   Stages (Q16.16 by default): one input stage, one multiply stage,
//   one discriminant stage, WORD_BITS+1 square root stages (one root bit
//   each), one numerator stage, WORD_BITS+2+FRAC_BITS divider stages (one
//   quotient bit each, two lanes side by side) and the output register.
//   Throughput is one beat per cycle while the receiver does not stall;
//   the divider chain is the longest part of the pipeline.
//   Reset clears every valid bit; the pipeline starts empty.
//   When the receiver stalls with a result waiting, the whole pipeline
//   holds and coef_stall_o rises in the same cycle; nothing is dropped.
module quadratic_root_solver_core #(
  parameter int FRAC_BITS = qrs_pkg::FracBits
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          coef_valid_i,
  output logic          coef_stall_o,
  input  qrs_pkg::coef_t coef_i,
  output logic          root_valid_o,
  input  logic          root_stall_i,
  output qrs_pkg::root_t root_o
);
  import qrs_pkg::*;

  localparam int W    = WordBits;
  localparam int SW   = W + 1;          // square root width
  localparam int RW   = 2 * SW;         // radicand width
  localparam int REMW = SW + 2;         // square root remainder
  localparam int NW   = W + 2;          // numerator magnitude
  localparam int QW   = NW + FRAC_BITS; // dividend and quotient
  localparam int VW   = W + 1;          // divisor

  typedef struct packed {
    logic         valid;
    logic [1:0]   status;
    logic         neg_a;
    logic         neg_b;
    logic         neg_c;
    logic [W-1:0] mag_a;
    logic [W-1:0] mag_b;
    logic [W-1:0] mag_c;
  } info_t;

  typedef struct packed {
    info_t           info;
    logic [RW-1:0]   rad;
    logic [REMW-1:0] rem;
    logic [SW-1:0]   root;
  } sq_t;

  typedef struct packed {
    logic          valid;
    logic [1:0]    status;
    logic          qneg;
    logic [QW-1:0] dvd;
    logic [VW-1:0] div;
    logic [VW-1:0] rem;
  } dv_t;

  logic advance;
  assign advance      = !root_valid_o || !root_stall_i;
  assign coef_stall_o = !advance;

  // input stage
  logic  in_valid_q;
  coef_t in_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (advance) begin
      in_valid_q <= coef_valid_i;
    end
  end
  always_ff @(posedge clk_i) begin
    if (advance) begin
      in_q <= coef_i;
    end
  end

  // multiply stage
  logic         ng_a, ng_b, ng_c;
  logic [W-1:0] mg_a, mg_b, mg_c;
  logic signed [W+1:0] sum;
  assign ng_a = in_q.coef_a[W-1];
  assign ng_b = in_q.coef_b[W-1];
  assign ng_c = in_q.coef_c[W-1];
  assign mg_a = ng_a ? W'(-in_q.coef_a) : W'(in_q.coef_a);
  assign mg_b = ng_b ? W'(-in_q.coef_b) : W'(in_q.coef_b);
  assign mg_c = ng_c ? W'(-in_q.coef_c) : W'(in_q.coef_c);
  assign sum  = (W+2)'(in_q.coef_a) + (W+2)'(in_q.coef_b) + (W+2)'(in_q.coef_c);

  info_t          mul_d, mul_q;
  logic [2*W-1:0] b2_q, ac_q;
  always_comb begin
    mul_d        = '0;
    mul_d.valid  = in_valid_q;
    mul_d.neg_a  = ng_a;
    mul_d.neg_b  = ng_b;
    mul_d.neg_c  = ng_c;
    mul_d.mag_a  = mg_a;
    mul_d.mag_b  = mg_b;
    mul_d.mag_c  = mg_c;
    if (mg_a == '0) begin
      mul_d.status = StAZero;
    end else if (sum == '0) begin
      mul_d.status = StShortcut;
    end else begin
      mul_d.status = StFormula;
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_q <= '0;
    end else if (advance) begin
      mul_q <= mul_d;
    end
  end
  always_ff @(posedge clk_i) begin
    if (advance) begin
      b2_q <= mg_b * mg_b;
      ac_q <= mg_a * mg_c;
    end
  end

  // discriminant stage
  logic [RW-1:0] b2_x, ac4_x, disc;
  logic          ac_neg;
  sq_t           sq_q [SW+1];
  sq_t           sq_first;
  assign b2_x   = RW'(b2_q);
  assign ac4_x  = {ac_q, 2'b00};
  assign ac_neg = mul_q.neg_a ^ mul_q.neg_c;
  assign disc   = ac_neg ? (b2_x + ac4_x) : (b2_x - ac4_x);
  always_comb begin
    sq_first      = '0;
    sq_first.info = mul_q;
    sq_first.rad  = disc;
    if (mul_q.status == StFormula && !ac_neg && ac4_x > b2_x) begin
      sq_first.info.status = StNoReal;
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_q[0] <= '0;
    end else if (advance) begin
      sq_q[0] <= sq_first;
    end
  end

  // square root: one root bit per stage
  for (genvar k = 0; k < SW; k++) begin : g_sqrt
    logic [REMW+1:0] rem2, trial;
    logic            ge;
    sq_t             nxt;
    assign rem2  = {sq_q[k].rem, sq_q[k].rad[RW-1 -: 2]};
    assign trial = (REMW+2)'({sq_q[k].root, 2'b01});
    assign ge    = rem2 >= trial;
    always_comb begin
      nxt      = sq_q[k];
      nxt.rad  = {sq_q[k].rad[RW-3:0], 2'b00};
      nxt.rem  = ge ? REMW'(rem2 - trial) : REMW'(rem2);
      nxt.root = {sq_q[k].root[SW-2:0], ge};
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_q[k+1] <= '0;
      end else if (advance) begin
        sq_q[k+1] <= nxt;
      end
    end
  end

  // numerator stage: set up both divider lanes
  info_t            fin;
  logic signed [NW:0] mb, nb, n1, n2;
  dv_t              dv_q [2][QW+1];
  dv_t              ln_d [2];
  assign fin = sq_q[SW].info;
  assign mb  = (NW+1)'({3'b000, fin.mag_b});
  assign nb  = fin.neg_b ? mb : -mb;
  assign n1  = nb + (NW+1)'({2'b00, sq_q[SW].root});
  assign n2  = nb - (NW+1)'({2'b00, sq_q[SW].root});
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      ln_d[l]        = '0;
      ln_d[l].valid  = fin.valid;
      ln_d[l].status = fin.status;
      ln_d[l].div    = VW'(1);
    end
    if (fin.status == StShortcut) begin
      ln_d[0].dvd  = QW'(1) << FRAC_BITS;
      ln_d[1].dvd  = QW'({fin.mag_c, FRAC_BITS'(0)});
      ln_d[1].div  = VW'(fin.mag_a);
      ln_d[1].qneg = fin.neg_c ^ fin.neg_a;
    end else if (fin.status == StFormula) begin
      ln_d[0].dvd  = {NW'(n1[NW] ? -n1 : n1), FRAC_BITS'(0)};
      ln_d[0].div  = {fin.mag_a, 1'b0};
      ln_d[0].qneg = n1[NW] ^ fin.neg_a;
      ln_d[1].dvd  = {NW'(n2[NW] ? -n2 : n2), FRAC_BITS'(0)};
      ln_d[1].div  = {fin.mag_a, 1'b0};
      ln_d[1].qneg = n2[NW] ^ fin.neg_a;
    end
  end

  // divider lanes: one quotient bit per stage, quotient shifts into dvd
  for (genvar l = 0; l < 2; l++) begin : g_lane
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[l][0] <= '0;
      end else if (advance) begin
        dv_q[l][0] <= ln_d[l];
      end
    end
    for (genvar j = 0; j < QW; j++) begin : g_div
      logic [VW:0] rem2;
      logic        ge;
      dv_t         nxt;
      assign rem2 = {dv_q[l][j].rem, dv_q[l][j].dvd[QW-1]};
      assign ge   = rem2 >= {1'b0, dv_q[l][j].div};
      always_comb begin
        nxt     = dv_q[l][j];
        nxt.rem = ge ? VW'(rem2 - {1'b0, dv_q[l][j].div}) : VW'(rem2);
        nxt.dvd = {dv_q[l][j].dvd[QW-2:0], ge};
      end
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          dv_q[l][j+1] <= '0;
        end else if (advance) begin
          dv_q[l][j+1] <= nxt;
        end
      end
    end
  end

  // clamp and encode both roots
  logic [W-1:0] val [2];
  logic [1:0]   sat;
  always_comb begin
    logic          neg;
    logic [QW-1:0] q, lim;
    logic [W-1:0]  m;
    for (int l = 0; l < 2; l++) begin
      q      = dv_q[l][QW].dvd;
      neg    = dv_q[l][QW].qneg && (q != '0);
      lim    = (QW'(1) << (W-1)) - QW'(!neg);
      sat[l] = q > lim;
      m      = sat[l] ? lim[W-1:0] : q[W-1:0];
      val[l] = neg ? -m : m;
    end
  end

  root_t out_d;
  logic  fl;
  assign fl = dv_q[0][QW].status == StFormula || dv_q[0][QW].status == StShortcut;
  always_comb begin
    out_d.status      = dv_q[0][QW].status;
    out_d.root_first  = fl ? val[0] : '0;
    out_d.root_second = fl ? val[1] : '0;
    out_d.saturated   = fl && (sat != 2'b00);
  end

  logic out_valid_q;
  root_t out_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= dv_q[0][QW].valid;
    end
  end
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign root_valid_o = out_valid_q;
  assign root_o       = out_q;

endmodule

FILE: bench/quadratic_root_solver_core_tb.sv
// Self-checking bench for quadratic_root_solver_core: directed table, then random beats.
// Predicts roots with wide integer math; depends on qrs_pkg and the core RTL.
module quadratic_root_solver_core_tb;
  import qrs_pkg::*;

  localparam int Latency = 2 * WordBits + FracBits + 8;
  localparam longint CycleLimit = 400000;

  typedef struct {
    coef_t coef;
    logic  has_golden;
    root_t golden;
  } vec_t;

  logic  clk_i;
  logic  rst_ni;
  logic  coef_valid_i;
  logic  coef_stall_o;
  coef_t coef_i;
  logic  root_valid_o;
  logic  root_stall_i;
  root_t root_o;

  root_t  pending_roots[$];
  int     error_cnt;
  longint cycle_cnt;
  int     send_idle_pct;
  int     recv_stall_pct;
  logic   hold_off;
  logic   send_done;
  int     n_formula, n_shortcut, n_noreal, n_azero, n_sat;

  quadratic_root_solver_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .coef_valid_i(coef_valid_i),
    .coef_stall_o(coef_stall_o),
    .coef_i      (coef_i),
    .root_valid_o(root_valid_o),
    .root_stall_i(root_stall_i),
    .root_o      (root_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0d: %s", cycle_cnt, msg);
    error_cnt++;
  endtask

  // Clamp a sign-magnitude quotient to the word range.
  function automatic logic [WordBits-1:0] clamp_root(input logic neg, input logic [127:0] mag,
                                                     inout logic sat);
    logic [127:0] lim;
    lim = neg ? (128'd1 << (WordBits - 1)) : ((128'd1 << (WordBits - 1)) - 1);
    if (mag > lim) begin
      mag = lim;
      sat = 1'b1;
    end
    return neg ? WordBits'(-mag) : WordBits'(mag);
  endfunction

  function automatic logic [WordBits-1:0] frac_quot(input logic nneg, input logic [127:0] nmag,
                                                    input logic dneg, input logic [127:0] dmag,
                                                    inout logic sat);
    logic [127:0] q;
    q = (nmag << FracBits) / dmag;
    return clamp_root((nneg != dneg) && (q != 0), q, sat);
  endfunction

  function automatic logic [127:0] floor_sqrt(input logic [127:0] d);
    logic [127:0] r;
    r = 0;
    for (int i = 63; i >= 0; i--)
      if ((r | (128'd1 << i)) * (r | (128'd1 << i)) <= d) r |= 128'd1 << i;
    return r;
  endfunction

  function automatic root_t solve_roots(input coef_t c);
    root_t r;
    logic signed [127:0] a, b, cc, disc, s, n1, n2;
    logic sat;
    a = c.coef_a;
    b = c.coef_b;
    cc = c.coef_c;
    sat = 1'b0;
    r = '0;
    if (a == 0) begin
      r.status = StAZero;
    end else if (a + b + cc == 0) begin
      r.status = StShortcut;
      r.root_first = clamp_root(1'b0, 128'd1 << FracBits, sat);
      r.root_second = frac_quot(cc < 0, cc < 0 ? -cc : cc, a < 0, a < 0 ? -a : a, sat);
    end else begin
      disc = b * b - 4 * a * cc;
      if (disc < 0) begin
        r.status = StNoReal;
      end else begin
        s = floor_sqrt(disc);
        n1 = -b + s;
        n2 = -b - s;
        r.status = StFormula;
        r.root_first = frac_quot(n1 < 0, n1 < 0 ? -n1 : n1, a < 0, a < 0 ? -2 * a : 2 * a, sat);
        r.root_second = frac_quot(n2 < 0, n2 < 0 ? -n2 : n2, a < 0, a < 0 ? -2 * a : 2 * a,
                                  sat);
      end
    end
    r.saturated = sat;
    return r;
  endfunction

  function automatic logic [WordBits-1:0] rand_word();
    logic [WordBits-1:0] w;
    case ($urandom_range(0, 7))
      0: w = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
      1: w = 32'($signed($urandom_range(0, 16)) - 8) <<< FracBits;
      2: w = 32'($signed($urandom_range(0, 400)) - 200);
      3: w = 32'(int'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000);
      default: w = $urandom;
    endcase
    return w;
  endfunction

  // Random equations: picked roots or sum-zero triples, a zeroed, rest noise.
  function automatic coef_t rand_coef();
    coef_t c;
    int r1, r2, k;
    c.coef_a = rand_word();
    c.coef_b = rand_word();
    c.coef_c = rand_word();
    case ($urandom_range(0, 9))
      0, 1: c.coef_c = -(c.coef_a + c.coef_b);
      2, 3, 4: begin
        r1 = $signed($urandom_range(0, 40)) - 20;
        r2 = $signed($urandom_range(0, 40)) - 20;
        k = $signed($urandom_range(1, 2000)) * ($urandom_range(0, 1) ? 1 : -1);
        c.coef_a = k;
        c.coef_b = -k * (r1 + r2);
        c.coef_c = k * r1 * r2;
      end
      5: c.coef_a = 0;
      default: ;
    endcase
    return c;
  endfunction

  task automatic send_coef(input coef_t c);
    coef_valid_i <= 1'b1;
    coef_i <= c;
    pending_roots.push_back(solve_roots(c));
    do @(posedge clk_i); while (coef_stall_o);
    if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      coef_valid_i <= 1'b0;
      coef_i <= {$urandom, $urandom, $urandom};
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
  endtask

  task automatic run_random(input int cnt, input int idle, input int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (cnt) send_coef(rand_coef());
  endtask

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout with %0d results outstanding", pending_roots.size());
      $display("quadratic_root_solver_core verification failed");
      $finish;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_stall_i <= 1'b0;
    end else begin
      root_stall_i <= hold_off || (recv_stall_pct > 0 && $urandom_range(0, 99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    root_t want;
    if (rst_ni && root_valid_o && !root_stall_i) begin
      if (pending_roots.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = pending_roots.pop_front();
        if (root_o.root_first !== want.root_first)
          report_mismatch($sformatf("root_first %h want %h", root_o.root_first, want.root_first));
        if (root_o.root_second !== want.root_second)
          report_mismatch($sformatf("root_second %h want %h", root_o.root_second,
                                    want.root_second));
        if (root_o.status !== want.status)
          report_mismatch($sformatf("status %0d want %0d", root_o.status, want.status));
        if (root_o.saturated !== want.saturated)
          report_mismatch($sformatf("saturated %b want %b", root_o.saturated, want.saturated));
        case (want.status)
          StFormula:  n_formula++;
          StShortcut: n_shortcut++;
          StNoReal:   n_noreal++;
          default:    n_azero++;
        endcase
        if (want.saturated) n_sat++;
      end
    end
  end

  // Long receiver hold-off while the sender keeps offering beats back to back.
  initial begin
    hold_off = 1'b0;
    wait (send_done == 1'b0 && cycle_cnt > 200);
    hold_off = 1'b1;
    repeat (300) @(posedge clk_i);
    hold_off = 1'b0;
  end

  initial begin
    vec_t table_rows[$];
    vec_t row;
    error_cnt = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_done = 1'b0;
    coef_valid_i = 1'b0;
    coef_i = '0;
    rst_ni = 1'b0;
    {n_formula, n_shortcut, n_noreal, n_azero, n_sat} = '0;

    // a, b, c, typed expectation where obvious
    table_rows = '{
      '{'{32'h0, 32'h0, 32'h0}, 1'b1, '{32'h0, 32'h0, StAZero, 1'b0}},
      '{'{32'h0, 32'h7fff_ffff, 32'h8000_0000}, 1'b1, '{32'h0, 32'h0, StAZero, 1'b0}},
      '{'{32'h0001_0000, 32'h0, 32'h0001_0000}, 1'b1, '{32'h0, 32'h0, StNoReal, 1'b0}},
      '{'{32'h0001_0000, 32'hfffe_0000, 32'h0001_0000}, 1'b1,
        '{32'h0001_0000, 32'h0001_0000, StShortcut, 1'b0}},
      '{'{32'h0001_0000, 32'hfffd_0000, 32'h0002_0000}, 1'b1,
        '{32'h0001_0000, 32'h0002_0000, StShortcut, 1'b0}},
      '{'{32'h0001_0000, 32'h0, 32'hffff_0000}, 1'b1,
        '{32'h0001_0000, 32'hffff_0000, StShortcut, 1'b0}},
      '{'{32'h0001_0000, 32'h0, 32'hfffc_0000}, 1'b0, '0},
      '{'{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff}, 1'b0, '0},
      '{'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, 1'b0, '0},
      '{'{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001}, 1'b0, '0},
      '{'{32'h0000_0001, 32'h8000_0000, 32'h0}, 1'b0, '0},
      '{'{32'h0000_0001, 32'h7fff_ffff, 32'h8000_0000}, 1'b0, '0},
      '{'{32'hffff_ffff, 32'h7fff_ffff, 32'h7fff_ffff}, 1'b0, '0},
      '{'{32'h0000_0001, 32'h0, 32'h8000_0000}, 1'b0, '0},
      '{'{32'h7fff_ffff, 32'h8000_0001, 32'h0}, 1'b0, '0},
      '{'{32'h0000_0001, 32'hffff_ffff, 32'h0}, 1'b0, '0},
      '{'{32'h0002_0000, 32'h0003_0000, 32'hfffb_0000}, 1'b0, '0},
      '{'{32'hffff_0000, 32'h0005_0000, 32'hfffa_0000}, 1'b0, '0},
      '{'{32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555}, 1'b0, '0},
      '{'{32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa}, 1'b0, '0}
    };

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (table_rows[i]) begin
      row = table_rows[i];
      send_coef(row.coef);
      if (row.has_golden) pending_roots[pending_roots.size() - 1] = row.golden;
    end

    run_random(400, 0, 0);
    run_random(450, 83, 0);
    run_random(450, 0, 83);
    run_random(350, 15, 15);
    send_done = 1'b1;
    coef_valid_i <= 1'b0;
    recv_stall_pct = 0;

    while (pending_roots.size() != 0) @(posedge clk_i);
    repeat (Latency + 20) @(posedge clk_i);

    $display("covered: %0d formula, %0d shortcut, %0d no-real, %0d a-zero results",
             n_formula, n_shortcut, n_noreal, n_azero);
    $display("%0d saturated results, %0d mismatches", n_sat, error_cnt);
    if (error_cnt == 0) begin
      $display("quadratic_root_solver_core verification clean");
    end else begin
      $display("quadratic_root_solver_core verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/qrs_pkg.sv
rtl/quadratic_root_solver_core.sv
bench/quadratic_root_solver_core_tb.sv
